FILE: sv/sha_pkg.sv
// package: sha-256 constants, round table and shared types
package sha_pkg;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;
  localparam int unsigned TotalWidth = 61;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    logic put;
    logic [7:0] put_value;
    logic count;
    logic load_round;
    logic do_round;
    logic finish;
    logic write_len;
    logic clear_all;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic round_done;
  } dp_status_t;

  function automatic word_t iv_word(input logic [2:0] i);
    case (i)
      3'd0: iv_word = 32'h6A09E667;
      3'd1: iv_word = 32'hBB67AE85;
      3'd2: iv_word = 32'h3C6EF372;
      3'd3: iv_word = 32'hA54FF53A;
      3'd4: iv_word = 32'h510E527F;
      3'd5: iv_word = 32'h9B05688C;
      3'd6: iv_word = 32'h1F83D9AB;
      default: iv_word = 32'h5BE0CD19;
    endcase
  endfunction

  localparam word_t RoundK [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };
endpackage

FILE: sv/sha_datapath.sv
// datapath: block buffer, schedule window, round unit and hash state
module sha_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::dp_cmd_t    cmd,
  output sha_pkg::dp_status_t status,
  output logic [255:0]        digest
);
  import sha_pkg::*;

  word_t w [BlockWords];
  word_t hw [8];
  word_t a, b, c, d, e, f, g, h;
  logic [5:0] fill;
  logic [5:0] rnd;
  logic [TotalWidth-1:0] total;
  logic [63:0] bits;
  word_t s0, s1, w_new, big0, big1, choose, major, t1, t2;
  logic [3:0] pidx;
  logic [4:0] psh;

  assign bits = {total, 3'b000};
  assign s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign w_new = w[0] + s0 + w[9] + s1;
  assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign choose = (e & f) ^ (~e & g);
  assign t1 = h + big1 + choose + RoundK[rnd] + w[0];
  assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign major = (a & b) ^ (a & c) ^ (b & c);
  assign t2 = big0 + major;
  assign pidx = fill[5:2];
  assign psh = 5'({~fill[1:0], 3'b000});

  assign status.fill = fill;
  assign status.round_done = (rnd == 6'd63);
  assign digest = {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < 8; i++) hw[i] <= iv_word(3'(i));
      for (int i = 0; i < BlockWords; i++) w[i] <= '0;
      fill <= '0;
      total <= '0;
      rnd <= '0;
    end else begin
      if (cmd.put) begin
        w[pidx] <= (w[pidx] & ~(32'hFF << psh)) | (word_t'(cmd.put_value) << psh);
        fill <= fill + 6'd1;
      end
      if (cmd.count) total <= total + TotalWidth'(1);
      if (cmd.write_len) begin
        w[14] <= bits[63:32];
        w[15] <= bits[31:0];
      end
      if (cmd.load_round) begin
        a <= hw[0]; b <= hw[1]; c <= hw[2]; d <= hw[3];
        e <= hw[4]; f <= hw[5]; g <= hw[6]; h <= hw[7];
        rnd <= '0;
      end
      if (cmd.do_round) begin
        h <= g; g <= f; f <= e; e <= d + t1;
        d <= c; c <= b; b <= a; a <= t1 + t2;
        for (int i = 0; i < BlockWords - 1; i++) w[i] <= w[i+1];
        w[BlockWords-1] <= w_new;
        rnd <= rnd + 6'd1;
      end
      if (cmd.finish) begin
        hw[0] <= hw[0] + a; hw[1] <= hw[1] + b; hw[2] <= hw[2] + c; hw[3] <= hw[3] + d;
        hw[4] <= hw[4] + e; hw[5] <= hw[5] + f; hw[6] <= hw[6] + g; hw[7] <= hw[7] + h;
        for (int i = 0; i < BlockWords; i++) w[i] <= '0;
        fill <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.do_round |-> !cmd.put)
    else $error("byte written during rounds");
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> $past(cmd.do_round))
    else $error("finish without rounds");
endmodule

FILE: sv/sha_control.sv
// controller: byte intake, padding sequence, compression and output handshake
module sha_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_has,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output sha_pkg::dp_cmd_t    cmd,
  input  sha_pkg::dp_status_t status,
  output logic                grab
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_FINISH, S_PAD, S_LEN, S_DONE
  } state_t;

  state_t state;
  logic fin, len_done, pad_done;
  logic acc;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    grab = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc && in_has) begin
          cmd.put = 1'b1;
          cmd.put_value = in_byte;
          cmd.count = 1'b1;
        end
      end
      S_PAD: begin
        cmd.put = 1'b1;
        cmd.put_value = PadByte;
      end
      S_LEN: cmd.write_len = 1'b1;
      S_ROUND: cmd.do_round = 1'b1;
      S_FINISH: cmd.finish = 1'b1;
      S_DONE: begin
        if (out_free) begin
          grab = 1'b1;
          cmd.clear_all = 1'b1;
        end
      end
      default: ;
    endcase
    if ((state == S_IDLE && acc && in_has && status.fill == 6'd63) ||
        (state == S_LEN) || (state == S_PAD && status.fill >= 6'd56))
      cmd.load_round = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
      len_done <= 1'b0;
      pad_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            fin <= in_last;
            pad_done <= 1'b0;
            len_done <= 1'b0;
            if (in_has && status.fill == 6'd63) state <= S_ROUND;
            else if (in_last) state <= S_PAD;
          end
        end
        S_PAD: begin
          pad_done <= 1'b1;
          state <= (status.fill >= 6'd56) ? S_ROUND : S_LEN;
        end
        S_LEN: begin
          len_done <= 1'b1;
          state <= S_ROUND;
        end
        S_ROUND: if (status.round_done) state <= S_FINISH;
        S_FINISH: begin
          if (!fin) state <= S_IDLE;
          else if (!pad_done) state <= S_PAD;
          else if (!len_done) state <= S_LEN;
          else state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) grab |-> !(out_valid && !out_ready))
    else $error("result overwritten");
endmodule

FILE: sv/sha256_hash_core.sv
// sha256_hash_core: byte-stream sha-256 hasher, top level
// s_axis carries one message byte per transaction; tuser flags whether the byte is
// present, tlast ends the message (an empty last transaction is allowed).
// m_axis carries one 256-bit digest per message.
// a byte that does not fill a block leaves the core ready for the next byte.
// the 64th byte of a block starts a compression: the shared round unit runs
// the rounds one by one, then the result is folded into the hash state, and
// no byte is taken while it runs. a last transaction adds a pad step, a
// length step and one or two compressions, then the digest is registered.
// the digest waits in an output register; the next message is accepted while
// it waits, but the next digest stalls until the earlier one is taken.
// reset restores the initial hash vector and an empty buffer at once.
module sha256_hash_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // has_byte
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // digest_word01, digest_word23, digest_word45, digest_word67
);
  import sha_pkg::*;

  dp_cmd_t cmd;
  dp_status_t status;
  logic [255:0] digest;
  logic grab;

  sha_control u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_has(s_axis_tuser), .in_last(s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .status(status), .grab(grab)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .digest(digest)
  );

  always_ff @(posedge clk) begin
    if (grab) m_axis_tdata <= {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
  end

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid && !m_axis_tready |=>
    $stable(m_axis_tdata)) else $error("digest changed while stalled");
endmodule

FILE: verif/tb.sv
// tb: self-checking testbench for sha256_hash_core, byte stream in, digest out
module tb;
  import sha_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       drain;
  } byte_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;

  sha256_hash_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_item_t   pending [$];
  logic [255:0] digests_due [$];
  word_t        hash_st [8];
  word_t        msg_blk [16];
  int unsigned  fill_pos;
  logic [60:0]  msg_bytes;
  int unsigned  errors = 0;
  int unsigned  items_in = 0;
  int unsigned  digests_out = 0;
  int unsigned  msg_count = 0;
  int unsigned  cycles = 0;
  int unsigned  snd_gap = 0;
  int unsigned  rcv_gap = 0;
  int unsigned  long_hold = 0;
  bit           long_done = 1'b0;
  bit           xfer_done = 1'b0;
  bit           quiet;

  assign quiet = pending.size() < 150;

  function automatic word_t rotr(word_t v, int unsigned d);
    return (v >> d) | (v << (32 - d));
  endfunction

  function automatic void hash_reset();
    for (int i = 0; i < 8; i++) hash_st[i] = iv_word(i[2:0]);
    for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    fill_pos = 0;
    msg_bytes = '0;
  endfunction

  function automatic void compress();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + RoundK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    for (int i = 0; i < 16; i++) msg_blk[i] = '0;
  endfunction

  function automatic void put_byte(int unsigned pos, logic [7:0] v);
    msg_blk[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
  endfunction

  function automatic void hash_byte(byte_item_t it);
    logic [63:0] bit_len;
    if (it.has) begin
      put_byte(fill_pos, it.data);
      msg_bytes = msg_bytes + 61'd1;
      fill_pos++;
      if (fill_pos == 64) begin
        compress();
        fill_pos = 0;
      end
    end
    if (it.fin) begin
      put_byte(fill_pos, PadByte);
      if (fill_pos >= 56) compress();
      bit_len = {msg_bytes, 3'b000};
      msg_blk[14] = bit_len[63:32];
      msg_blk[15] = bit_len[31:0];
      compress();
      digests_due.push_back({hash_st[6], hash_st[7], hash_st[4], hash_st[5],
                             hash_st[2], hash_st[3], hash_st[0], hash_st[1]});
      hash_reset();
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_item(logic [7:0] d, logic has, logic fin);
    byte_item_t it;
    it.data = d; it.has = has; it.fin = fin; it.drain = 1'b0;
    pending.push_back(it);
  endfunction

  function automatic void push_msg(int unsigned len, bit empty_end, bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) push_item(rand_byte(), 1'b0, 1'b0);
      push_item(rand_byte(), 1'b1, (i == len - 1) && !empty_end);
    end
    if (len == 0 || empty_end) push_item(rand_byte(), 1'b0, 1'b1);
    msg_count++;
  endfunction

  initial hash_reset();

  // input acceptance, prediction, output check, timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    xfer_done <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      hash_byte(pending[0]);
      void'(pending.pop_front());
      items_in <= items_in + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      digests_out <= digests_out + 1;
      if (digests_due.size() == 0) begin
        $display("%0t: unexpected digest %h", $time, m_axis_tdata);
        errors++;
      end else begin
        for (int k = 0; k < 4; k++)
          if (m_axis_tdata[64*k +: 64] !== digests_due[0][64*k +: 64]) begin
            $display("%0t: digest_word%0d%0d expected %h actual %h", $time, 2*k, 2*k+1,
                     digests_due[0][64*k +: 64], m_axis_tdata[64*k +: 64]);
            errors++;
          end
        void'(digests_due.pop_front());
      end
    end
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !xfer_done)) begin
      if (pending.size() > 0 && pending[0].drain && digests_due.size() == 0)
        void'(pending.pop_front());
      if (snd_gap > 0) begin
        snd_gap <= snd_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snd_gap <= $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() > 0 && !pending[0].drain) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending[0].data;
        s_axis_tuser <= pending[0].has;
        s_axis_tlast <= pending[0].fin;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!long_done && items_in >= 400) begin
      long_done <= 1'b1;
      long_hold <= 400;
      m_axis_tready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rcv_gap <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int unsigned len;
    byte_item_t stop_item;
    bit drain_added;
    drain_added = 1'b0;
    // empty message, "abc", single extreme bytes, ignored items, empty last
    push_msg(0, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    msg_count++;
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hA5, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    msg_count += 3;
    push_msg(0, 1'b1, 1'b0);
    while (pending.size() < 1700) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 11))
          0: len = 0;
          1: len = 54;
          2: len = 55;
          3: len = 56;
          4: len = 57;
          5: len = 62;
          6: len = 63;
          7: len = 64;
          8: len = 65;
          9: len = 119;
          10: len = 120;
          default: len = 128;
        endcase
      end else begin
        len = $urandom_range(1, 40);
      end
      push_msg(len, $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
      if (!drain_added && pending.size() > 900) begin
        stop_item.data = '0; stop_item.has = 1'b0; stop_item.fin = 1'b0;
        stop_item.drain = 1'b1;
        pending.push_back(stop_item);
        drain_added = 1'b1;
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0);
    wait (digests_due.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d messages, %0d byte transactions, %0d digests checked", msg_count, items_in,
             digests_out);
    $display("covered padding boundaries, empty messages, multi-block and ignored transactions");
    if (errors == 0 && digests_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

FILE: sim.f
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_control.sv
sv/sha256_hash_core.sv
verif/tb.sv
